/* rtl/core/heightmap_height_and_shade_query_defines.svh */
// Assertion macros for the heightmap query block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef HEIGHTMAP_HEIGHT_AND_SHADE_QUERY_DEFINES_SVH
`define HEIGHTMAP_HEIGHT_AND_SHADE_QUERY_DEFINES_SVH

// same-cycle implication
`define HHSQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HHSQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/hhsq_pkg.sv */
// Shared types and constants of the heightmap query block.
// No dependencies.
package hhsq_pkg;

  localparam int MAX_ROW_VERTS_DEF = 256;
  localparam int MAX_COL_VERTS_DEF = 256;
  localparam int QUEUE_DEPTH_DEF   = 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_VERTS_ROW = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERTS_COL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACING   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_Y   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_Z   = 3'd5;

  localparam logic [1:0] ACT_WRITE  = 2'd0;
  localparam logic [1:0] ACT_HEIGHT = 2'd1;
  localparam logic [1:0] ACT_SHADE  = 2'd2;

  localparam logic [14:0] SHADE_ONE = 15'd16384;

  typedef enum logic [1:0] {OP_NONE, OP_WRITE, OP_HEIGHT, OP_SHADE} op_t;

  // effective configuration (sizes clamped, spacing nonzero)
  typedef struct packed {
    logic [8:0]         vpr;
    logic [8:0]         vpc;
    logic [7:0]         spc;
    logic signed [15:0] lx;
    logic signed [15:0] ly;
    logic signed [15:0] lz;
  } cfg_t;

  // classified request handed from front to back
  typedef struct packed {
    op_t         op;
    logic        err;
    logic [15:0] value;
    logic [15:0] rx;
    logic [15:0] rz;
  } req_t;

endpackage

/* rtl/core/hhsq_ram.sv */
// Generic simple dual-port RAM, registered read.
// No dependencies.
module hhsq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/hhsq_fifo.sv */
// Short request queue between front and back, show-ahead output.
// No dependencies.
module hhsq_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty,
  output logic             full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] buf_r [DEPTH];
  logic [PW-1:0]    wptr_r, rptr_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push, do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == CW'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = buf_r[rptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      buf_r[wptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

/* rtl/core/hhsq_front.sv */
// Front end: takes requests, range-checks them, locates the cell of a
// height query with a bit-serial divide. Depends on hhsq_pkg.
module hhsq_front
  import hhsq_pkg::*;
#(
  parameter int AW = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cfg_t                   cfg,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             in_action,
  input  logic [7:0]             in_row,
  input  logic [7:0]             in_col,
  input  logic [15:0]            in_value,
  input  logic signed [23:0]     in_pos_x,
  input  logic signed [23:0]     in_pos_z,
  output logic                   push,
  output req_t                   push_req,
  output logic [AW-1:0]          push_addr,
  input  logic                   full
);

  localparam int DIV_STEPS = 17;

  typedef enum logic [2:0] {F_IDLE, F_CLASS, F_DIV, F_FIN, F_PUSH} fstate_t;

  fstate_t            state_r;
  logic [1:0]         act_r;
  logic [8:0]         row_r, col_r;
  logic signed [23:0] px_r, pz_r;
  req_t               req_r;
  logic [16:0]        nx_r, nz_r;
  logic [7:0]         remx_r, remz_r, lowx_r, lowz_r;
  logic [4:0]         cnt_r;

  logic [8:0]         vprm1, vpcm1;
  logic [16:0]        wx, wz;
  logic signed [25:0] xq, zq;
  logic [15:0]        span;
  logic [8:0]         shx, shz;
  logic               gex, gez;
  logic               edge_x, edge_z, bad_x, bad_z;
  logic [17:0]        addr_full;

  assign vprm1 = cfg.vpr - 9'd1;
  assign vpcm1 = cfg.vpc - 9'd1;
  assign wx    = {8'b0, vprm1} * {9'b0, cfg.spc};
  assign wz    = {8'b0, vpcm1} * {9'b0, cfg.spc};
  // move grid centre to origin, z axis flipped
  assign xq    = $signed({2'b0, wx, 7'b0}) + $signed({{2{px_r[23]}}, px_r});
  assign zq    = $signed({2'b0, wz, 7'b0}) - $signed({{2{pz_r[23]}}, pz_r});
  assign span  = {cfg.spc, 8'b0};

  // one restoring step per cycle on x and z together
  assign shx = {remx_r, nx_r[16]};
  assign shz = {remz_r, nz_r[16]};
  assign gex = shx >= {1'b0, cfg.spc};
  assign gez = shz >= {1'b0, cfg.spc};

  // a point exactly on the far edge belongs to the last cell
  assign edge_x = (nx_r == {8'b0, vprm1}) && (remx_r == '0) && (lowx_r == '0);
  assign edge_z = (nz_r == {8'b0, vpcm1}) && (remz_r == '0) && (lowz_r == '0);
  assign bad_x  = !edge_x && (nx_r >= {8'b0, vprm1});
  assign bad_z  = !edge_z && (nz_r >= {8'b0, vpcm1});

  assign addr_full = ({9'b0, row_r} * {9'b0, cfg.vpr}) + {9'b0, col_r};

  assign busy      = (state_r != F_IDLE);
  assign push      = (state_r == F_PUSH) && !full;
  assign push_req  = req_r;
  assign push_addr = AW'(addr_full);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (start) begin
            act_r       <= in_action;
            row_r       <= {1'b0, in_row};
            col_r       <= {1'b0, in_col};
            px_r        <= in_pos_x;
            pz_r        <= in_pos_z;
            req_r.value <= in_value;
            req_r.rx    <= '0;
            req_r.rz    <= '0;
            state_r     <= F_CLASS;
          end
        end
        F_CLASS: begin
          state_r <= F_PUSH;
          case (act_r)
            ACT_WRITE: begin
              req_r.op  <= OP_WRITE;
              req_r.err <= !((row_r < cfg.vpc) && (col_r < cfg.vpr));
            end
            ACT_SHADE: begin
              req_r.op  <= OP_SHADE;
              req_r.err <= !((({1'b0, row_r} + 10'd2) <= {1'b0, cfg.vpc}) &&
                             (({1'b0, col_r} + 10'd2) <= {1'b0, cfg.vpr}));
            end
            ACT_HEIGHT: begin
              req_r.op  <= OP_HEIGHT;
              req_r.err <= xq[25] || zq[25];
              if (!xq[25] && !zq[25]) begin
                nx_r    <= xq[24:8];
                nz_r    <= zq[24:8];
                lowx_r  <= xq[7:0];
                lowz_r  <= zq[7:0];
                remx_r  <= '0;
                remz_r  <= '0;
                cnt_r   <= 5'(DIV_STEPS);
                state_r <= F_DIV;
              end
            end
            default: begin
              req_r.op  <= OP_NONE;
              req_r.err <= 1'b0;
            end
          endcase
        end
        F_DIV: begin
          remx_r <= gex ? 8'(shx - {1'b0, cfg.spc}) : shx[7:0];
          remz_r <= gez ? 8'(shz - {1'b0, cfg.spc}) : shz[7:0];
          nx_r   <= {nx_r[15:0], gex};
          nz_r   <= {nz_r[15:0], gez};
          cnt_r  <= cnt_r - 5'd1;
          if (cnt_r == 5'd1) begin
            state_r <= F_FIN;
          end
        end
        F_FIN: begin
          req_r.err <= bad_x || bad_z;
          col_r     <= edge_x ? vprm1 - 9'd1 : nx_r[8:0];
          row_r     <= edge_z ? vpcm1 - 9'd1 : nz_r[8:0];
          req_r.rx  <= edge_x ? span : {remx_r, lowx_r};
          req_r.rz  <= edge_z ? span : {remz_r, lowz_r};
          state_r   <= F_PUSH;
        end
        F_PUSH: begin
          if (!full) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/hhsq_back.sv */
// Back end: owns the height store port, reads cell corners, interpolates
// heights and computes shading. Depends on hhsq_pkg.
module hhsq_back
  import hhsq_pkg::*;
#(
  parameter int AW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cfg_t          cfg,
  input  logic          q_empty,
  output logic          q_pop,
  input  req_t          q_req,
  input  logic [AW-1:0] q_addr,
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output logic [15:0]   mem_wdata,
  output logic [AW-1:0] mem_raddr,
  input  logic [15:0]   mem_rdata,
  output logic          out_valid,
  output logic [23:0]   out_height,
  output logic [14:0]   out_shade,
  output logic          out_error
);

  localparam int HDIV_STEPS = 34;

  typedef enum logic [4:0] {
    B_IDLE, B_RA, B_RB, B_RC, B_RD, B_RE,
    B_H0, B_H1, B_H2, B_HPRE, B_HDIV,
    B_S0, B_S1, B_S2, B_S3, B_S4, B_S5, B_SCHK,
    B_L0, B_L1, B_L2, B_L3
  } bstate_t;

  bstate_t            state_r;
  req_t               req_r;
  logic [AW-1:0]      addr_r;
  logic [15:0]        ha_r, hb_r, hc_r, hd_r;
  logic signed [35:0] acc_r, dot_r;
  logic [33:0]        div_n_r, l2_r;
  logic [8:0]         rem_r;
  logic [5:0]         cnt_r;
  logic [63:0]        rhs_r;
  logic [31:0]        kk_r;
  logic [65:0]        p_r;
  logic [14:0]        q_r, bit_r;
  logic               out_valid_r, out_error_r;
  logic [23:0]        out_height_r;
  logic [14:0]        out_shade_r;

  logic [15:0]        span, h0, w1, w2;
  logic               upper;
  logic signed [16:0] d1, d2, a, c;
  logic [31:0]        base_prod;
  logic signed [33:0] prod1, prod2, sq_a, sq_c;
  logic signed [32:0] p_alx, p_sly, p_clz;
  logic [15:0]        sq_s;
  logic [9:0]         rem_sh, dv;
  logic               ge;
  logic [61:0]        dd;
  logic [14:0]        t, q_new;
  logic [15:0]        k;
  logic [31:0]        kk_w;
  logic [48:0]        pl, ph;
  logic               take;

  // ---- height interpolation operands
  assign span  = {cfg.spc, 8'b0};
  assign upper = ({1'b0, req_r.rx} + {1'b0, req_r.rz}) < {1'b0, span};
  assign h0    = upper ? ha_r : hd_r;
  assign d1    = upper ? $signed({1'b0, hb_r}) - $signed({1'b0, ha_r})
                       : $signed({1'b0, hc_r}) - $signed({1'b0, hd_r});
  assign d2    = upper ? $signed({1'b0, hc_r}) - $signed({1'b0, ha_r})
                       : $signed({1'b0, hb_r}) - $signed({1'b0, hd_r});
  assign w1    = upper ? req_r.rx : span - req_r.rx;
  assign w2    = upper ? req_r.rz : span - req_r.rz;
  assign base_prod = h0 * span;
  assign prod1 = d1 * $signed({1'b0, w1});
  assign prod2 = d2 * $signed({1'b0, w2});

  // rounding divide by 2s, one quotient bit a cycle
  assign dv     = {1'b0, cfg.spc, 1'b0};
  assign rem_sh = {rem_r, div_n_r[33]};
  assign ge     = rem_sh >= dv;

  // ---- shade operands
  assign a     = $signed({1'b0, hb_r}) - $signed({1'b0, ha_r});
  assign c     = $signed({1'b0, hc_r}) - $signed({1'b0, ha_r});
  assign p_alx = a * cfg.lx;
  assign p_sly = $signed({1'b0, cfg.spc}) * cfg.ly;
  assign p_clz = c * cfg.lz;
  assign sq_a  = a * a;
  assign sq_c  = c * c;
  assign sq_s  = cfg.spc * cfg.spc;
  assign dd    = dot_r[30:0] * dot_r[30:0];

  // bit search for largest q with (2q-1)^2 * |n|^2 <= 4 dot^2
  assign t     = q_r | bit_r;
  assign k     = {t, 1'b0} - 16'd1;
  assign kk_w  = k * k;
  assign pl    = kk_r * l2_r[16:0];
  assign ph    = kk_r * l2_r[33:17];
  assign take  = p_r <= {2'b0, rhs_r};
  assign q_new = take ? t : q_r;

  // ---- memory port
  assign q_pop     = (state_r == B_IDLE) && !q_empty;
  assign mem_we    = q_pop && (q_req.op == OP_WRITE) && !q_req.err;
  assign mem_waddr = q_addr;
  assign mem_wdata = q_req.value;

  always_comb begin
    case (state_r)
      B_RB:    mem_raddr = addr_r + AW'(1);
      B_RC:    mem_raddr = addr_r + AW'(cfg.vpr);
      B_RD:    mem_raddr = addr_r + AW'(cfg.vpr) + AW'(1);
      default: mem_raddr = addr_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            req_r  <= q_req;
            addr_r <= q_addr;
            if (!q_req.err && (q_req.op == OP_HEIGHT || q_req.op == OP_SHADE)) begin
              state_r <= B_RA;
            end else begin
              out_valid_r  <= 1'b1;
              out_height_r <= '0;
              out_shade_r  <= '0;
              out_error_r  <= q_req.err;
            end
          end
        end
        B_RA: state_r <= B_RB;
        B_RB: begin
          ha_r    <= mem_rdata;
          state_r <= B_RC;
        end
        B_RC: begin
          hb_r    <= mem_rdata;
          state_r <= B_RD;
        end
        B_RD: begin
          hc_r    <= mem_rdata;
          state_r <= B_RE;
        end
        B_RE: begin
          hd_r    <= mem_rdata;
          state_r <= (req_r.op == OP_HEIGHT) ? B_H0 : B_S0;
        end
        B_H0: begin
          acc_r   <= $signed({4'b0, base_prod});
          state_r <= B_H1;
        end
        B_H1: begin
          acc_r   <= acc_r + $signed({{2{prod1[33]}}, prod1});
          state_r <= B_H2;
        end
        B_H2: begin
          acc_r   <= acc_r + $signed({{2{prod2[33]}}, prod2});
          state_r <= B_HPRE;
        end
        B_HPRE: begin
          div_n_r <= {acc_r[32:0], 1'b0} + {26'b0, cfg.spc};
          rem_r   <= '0;
          cnt_r   <= 6'(HDIV_STEPS);
          state_r <= B_HDIV;
        end
        B_HDIV: begin
          rem_r   <= ge ? 9'(rem_sh - dv) : rem_sh[8:0];
          div_n_r <= {div_n_r[32:0], ge};
          cnt_r   <= cnt_r - 6'd1;
          if (cnt_r == 6'd1) begin
            out_valid_r  <= 1'b1;
            out_height_r <= {div_n_r[22:0], ge};
            out_shade_r  <= '0;
            out_error_r  <= 1'b0;
            state_r      <= B_IDLE;
          end
        end
        B_S0: begin
          dot_r   <= -$signed({{3{p_alx[32]}}, p_alx});
          state_r <= B_S1;
        end
        B_S1: begin
          dot_r   <= dot_r + $signed({{3{p_sly[32]}}, p_sly});
          state_r <= B_S2;
        end
        B_S2: begin
          dot_r   <= dot_r + $signed({{3{p_clz[32]}}, p_clz});
          state_r <= B_S3;
        end
        B_S3: begin
          l2_r    <= $unsigned(sq_a);
          state_r <= B_S4;
        end
        B_S4: begin
          l2_r    <= l2_r + {18'b0, sq_s};
          state_r <= B_S5;
        end
        B_S5: begin
          l2_r    <= l2_r + $unsigned(sq_c);
          state_r <= B_SCHK;
        end
        B_SCHK: begin
          if (dot_r[35] || (dot_r == '0) || (dot_r[34:31] != '0)) begin
            // facing away gives zero, a very large dot saturates
            out_valid_r  <= 1'b1;
            out_height_r <= '0;
            out_shade_r  <= (dot_r[35] || (dot_r == '0)) ? '0 : SHADE_ONE;
            out_error_r  <= 1'b0;
            state_r      <= B_IDLE;
          end else begin
            rhs_r   <= {dd, 2'b0};
            q_r     <= '0;
            bit_r   <= SHADE_ONE;
            state_r <= B_L0;
          end
        end
        B_L0: begin
          if (t <= SHADE_ONE) begin
            kk_r    <= kk_w;
            state_r <= B_L1;
          end else if (bit_r == 15'd1) begin
            out_valid_r  <= 1'b1;
            out_height_r <= '0;
            out_shade_r  <= q_r;
            out_error_r  <= 1'b0;
            state_r      <= B_IDLE;
          end else begin
            bit_r <= bit_r >> 1;
          end
        end
        B_L1: begin
          p_r     <= {17'b0, pl};
          state_r <= B_L2;
        end
        B_L2: begin
          p_r     <= p_r + {ph, 17'b0};
          state_r <= B_L3;
        end
        B_L3: begin
          q_r <= q_new;
          if (bit_r == 15'd1) begin
            out_valid_r  <= 1'b1;
            out_height_r <= '0;
            out_shade_r  <= q_new;
            out_error_r  <= 1'b0;
            state_r      <= B_IDLE;
          end else begin
            bit_r   <= bit_r >> 1;
            state_r <= B_L0;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_height = out_height_r;
  assign out_shade  = out_shade_r;
  assign out_error  = out_error_r;

endmodule

/* rtl/core/heightmap_height_and_shade_query.sv */
// Top level of the heightmap height and shade query block.
// Depends on hhsq_pkg, hhsq_front, hhsq_fifo, hhsq_back, hhsq_ram.
//
//   channel  ports                               handshake
//   request  in_action .. in_pos_z              start & !busy
//   result   out_height, out_shade, out_error   out_valid, one cycle, no stall
//   config   cfg_index, cfg_wdata               cfg_we
//
// Flow: the front classifies a request and, for a height query, runs the cell
// divide, then hands the request to a queue (2 deep by default). The back
// drains it: a write or a rejected request is answered from idle, a height
// query does four corner reads on the single read port, three MACs and a
// 34-step divide, a shade query six MACs and a 15-bit search. The back sets
// the sustained rate of height and shade queries; the front works ahead.
// Reset clears control state only; the height store holds garbage until
// written. The result side cannot stall.
`include "heightmap_height_and_shade_query_defines.svh"

module heightmap_height_and_shade_query
  import hhsq_pkg::*;
#(
  parameter int MAX_ROW_VERTS = MAX_ROW_VERTS_DEF,
  parameter int MAX_COL_VERTS = MAX_COL_VERTS_DEF,
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_action,
  input  logic [7:0]            in_row,
  input  logic [7:0]            in_col,
  input  logic [15:0]           in_value,
  input  logic signed [23:0]    in_pos_x,
  input  logic signed [23:0]    in_pos_z,
  output logic                  out_valid,
  output logic [23:0]           out_height,
  output logic [14:0]           out_shade,
  output logic                  out_error,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int DEPTH = MAX_ROW_VERTS * MAX_COL_VERTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int QW    = $bits(req_t) + AW;

  // raw configuration registers
  logic [8:0]         vpr_r, vpc_r;
  logic [7:0]         spc_r;
  logic signed [15:0] lx_r, ly_r, lz_r;
  cfg_t               cfg;

  logic               q_push, q_pop, q_empty, q_full;
  req_t               push_req, q_req;
  logic [AW-1:0]      push_addr, q_addr;
  logic [QW-1:0]      q_dout;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [15:0]        mem_wdata, mem_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vpr_r <= 9'd128;
      vpc_r <= 9'd128;
      spc_r <= 8'd10;
      lx_r  <= '0;
      ly_r  <= 16'sd16384;
      lz_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VERTS_ROW: vpr_r <= cfg_wdata[8:0];
        CFG_VERTS_COL: vpc_r <= cfg_wdata[8:0];
        CFG_SPACING:   spc_r <= cfg_wdata[7:0];
        CFG_LIGHT_X:   lx_r  <= cfg_wdata;
        CFG_LIGHT_Y:   ly_r  <= cfg_wdata;
        CFG_LIGHT_Z:   lz_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // effective sizes: clamped to [2, max], zero spacing acts as one
  always_comb begin
    if (vpr_r < 9'd2) begin
      cfg.vpr = 9'd2;
    end else if ({23'b0, vpr_r} > MAX_ROW_VERTS) begin
      cfg.vpr = 9'(MAX_ROW_VERTS);
    end else begin
      cfg.vpr = vpr_r;
    end
    if (vpc_r < 9'd2) begin
      cfg.vpc = 9'd2;
    end else if ({23'b0, vpc_r} > MAX_COL_VERTS) begin
      cfg.vpc = 9'(MAX_COL_VERTS);
    end else begin
      cfg.vpc = vpc_r;
    end
    cfg.spc = (spc_r == '0) ? 8'd1 : spc_r;
    cfg.lx  = lx_r;
    cfg.ly  = ly_r;
    cfg.lz  = lz_r;
  end

  hhsq_front #(.AW(AW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .start     (start),
    .busy      (busy),
    .in_action (in_action),
    .in_row    (in_row),
    .in_col    (in_col),
    .in_value  (in_value),
    .in_pos_x  (in_pos_x),
    .in_pos_z  (in_pos_z),
    .push      (q_push),
    .push_req  (push_req),
    .push_addr (push_addr),
    .full      (q_full)
  );

  hhsq_fifo #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   ({push_req, push_addr}),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty),
    .full  (q_full)
  );

  assign {q_req, q_addr} = q_dout;

  hhsq_back #(.AW(AW)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .q_req      (q_req),
    .q_addr     (q_addr),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata),
    .out_valid  (out_valid),
    .out_height (out_height),
    .out_shade  (out_shade),
    .out_error  (out_error)
  );

  hhsq_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // ---- checks
  `HHSQ_ASSERT_NOW(a_no_push_full, q_push, !q_full, "push into full queue")
  `HHSQ_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy, "accept without busy")
  `HHSQ_ASSERT_NOW(a_err_zero, out_valid && out_error, (out_height == '0) && (out_shade == '0), "error result not zero")
  `HHSQ_ASSERT_NOW(a_shade_range, out_valid, (out_shade <= SHADE_ONE) && ((out_height == '0) || (out_shade == '0)), "bad result fields")

endmodule
